>>> hw/rtl/websocket_frame_deframer_top_macros.svh
// Assertion helpers for the deframer top level.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WSFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/wsfd_pkg.sv
package wsfd_pkg;

	localparam int unsigned LEN_W = 64;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned HCNT_W = 4;

	// 7-bit length codes that select an extended length field
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	localparam logic [HCNT_W-1:0] EXT16_BYTES = 4'd2;
	localparam logic [HCNT_W-1:0] EXT64_BYTES = 4'd8;
	localparam logic [HCNT_W-1:0] KEY_BYTES = 4'd4;

	typedef struct packed {
		logic             valid;
		logic [7:0]       payload_byte;
		logic             has_payload;
		logic             frame_end;
		logic             fin;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] payload_length;
		logic             incomplete;
	} result_t;

endpackage

>>> hw/rtl/wsfd_parser.sv
module wsfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              buffer_end,
	output wsfd_pkg::result_t res
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN,
		PH_EXT,
		PH_KEY,
		PH_DATA
	} phase_t;

	phase_t                        phase_q, phase_n;
	logic [wsfd_pkg::HCNT_W-1:0]   hcnt_q, hcnt_n;
	logic [wsfd_pkg::LEN_W-1:0]    len_q, len_n;
	logic [wsfd_pkg::KEY_W-1:0]    key_q, key_n;
	logic [wsfd_pkg::LEN_W-1:0]    cnt_q, cnt_n;
	logic                          fin_q, fin_n;
	logic [3:0]                    op_q, op_n;
	logic                          masked_q, masked_n;

	logic       done;
	logic       has_pl;
	logic [7:0] pl_byte;
	logic [7:0] key_byte;
	logic [6:0] len7;

	always_comb begin
		phase_n  = phase_q;
		hcnt_n   = hcnt_q;
		len_n    = len_q;
		key_n    = key_q;
		cnt_n    = cnt_q;
		fin_n    = fin_q;
		op_n     = op_q;
		masked_n = masked_q;
		done     = 1'b0;
		has_pl   = 1'b0;
		pl_byte  = 8'd0;
		len7     = data_byte[6:0];
		key_byte = 8'd0;

		case (phase_q)
			PH_IDLE: begin
				fin_n    = data_byte[7];
				op_n     = data_byte[3:0];
				masked_n = 1'b0;
				len_n    = '0;
				key_n    = '0;
				cnt_n    = '0;
				hcnt_n   = '0;
				phase_n  = PH_LEN;
			end
			PH_LEN: begin
				masked_n = data_byte[7];
				if (len7 == wsfd_pkg::LEN_CODE_EXT16) begin
					len_n   = '0;
					hcnt_n  = wsfd_pkg::EXT16_BYTES;
					phase_n = PH_EXT;
				end else if (len7 == wsfd_pkg::LEN_CODE_EXT64) begin
					len_n   = '0;
					hcnt_n  = wsfd_pkg::EXT64_BYTES;
					phase_n = PH_EXT;
				end else begin
					len_n = {{(wsfd_pkg::LEN_W-7){1'b0}}, len7};
					if (masked_n) begin
						phase_n = PH_KEY;
						hcnt_n  = wsfd_pkg::KEY_BYTES;
					end else if (len_n == '0) begin
						done = 1'b1;
					end else begin
						phase_n = PH_DATA;
						cnt_n   = '0;
					end
				end
			end
			PH_EXT: begin
				// extended length arrives big-endian
				len_n  = {len_q[wsfd_pkg::LEN_W-9:0], data_byte};
				hcnt_n = hcnt_q - 4'd1;
				if (hcnt_n == '0) begin
					if (masked_q) begin
						phase_n = PH_KEY;
						hcnt_n  = wsfd_pkg::KEY_BYTES;
					end else if (len_n == '0) begin
						done = 1'b1;
					end else begin
						phase_n = PH_DATA;
						cnt_n   = '0;
					end
				end
			end
			PH_KEY: begin
				key_n  = {key_q[wsfd_pkg::KEY_W-9:0], data_byte};
				hcnt_n = hcnt_q - 4'd1;
				if (hcnt_n == '0) begin
					if (len_q == '0) begin
						done = 1'b1;
					end else begin
						phase_n = PH_DATA;
						cnt_n   = '0;
					end
				end
			end
			PH_DATA: begin
				// first key byte received sits in the top bits
				if (masked_q) begin
					case (cnt_q[1:0])
						2'd0: key_byte = key_q[31:24];
						2'd1: key_byte = key_q[23:16];
						2'd2: key_byte = key_q[15:8];
						default: key_byte = key_q[7:0];
					endcase
				end
				pl_byte = data_byte ^ key_byte;
				has_pl  = 1'b1;
				cnt_n   = cnt_q + 64'd1;
				if (cnt_n == len_q) begin
					done = 1'b1;
				end
			end
			default: begin
				phase_n  = PH_IDLE;
				hcnt_n   = '0;
				len_n    = '0;
				key_n    = '0;
				cnt_n    = '0;
				fin_n    = 1'b0;
				op_n     = '0;
				masked_n = 1'b0;
			end
		endcase

		// result carries header values as updated by this word
		res.valid          = done | buffer_end | has_pl;
		res.payload_byte   = pl_byte;
		res.has_payload    = has_pl;
		res.frame_end      = done;
		res.fin            = fin_n;
		res.opcode         = op_n;
		res.masked         = masked_n;
		res.payload_length = len_n;
		res.incomplete     = buffer_end & ~done;

		if (done) begin
			phase_n = PH_IDLE;
			hcnt_n  = '0;
			cnt_n   = '0;
		end else if (buffer_end) begin
			phase_n  = PH_IDLE;
			hcnt_n   = '0;
			len_n    = '0;
			key_n    = '0;
			cnt_n    = '0;
			fin_n    = 1'b0;
			op_n     = '0;
			masked_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hcnt_q   <= '0;
			len_q    <= '0;
			key_q    <= '0;
			cnt_q    <= '0;
			fin_q    <= 1'b0;
			op_q     <= '0;
			masked_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			hcnt_q   <= hcnt_n;
			len_q    <= len_n;
			key_q    <= key_n;
			cnt_q    <= cnt_n;
			fin_q    <= fin_n;
			op_q     <= op_n;
			masked_q <= masked_n;
		end
	end

endmodule

>>> hw/rtl/websocket_frame_deframer_top.sv
// Channel  Handshake           Word
// input    in_valid/in_stall   data_byte, buffer_end
// output   out_valid/out_stall payload_byte, has_payload, frame_end, fin, opcode,
//                              masked, payload_length, incomplete
//
// One byte per cycle sustained while neither side stalls.
// A taken byte passes the input register, the parser and the result register to the outputs.
// A word stalled on the output holds the parser; the input stage then fills and stalls.
// arst_n clears all control state; the parser returns to waiting for a header byte.
`include "websocket_frame_deframer_top_macros.svh"

module websocket_frame_deframer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       buffer_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 payload_byte,
	output logic                       has_payload,
	output logic                       frame_end,
	output logic                       fin,
	output logic [3:0]                 opcode,
	output logic                       masked,
	output logic [wsfd_pkg::LEN_W-1:0] payload_length,
	output logic                       incomplete
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              end_s1;
	logic              advance;
	wsfd_pkg::result_t res;
	wsfd_pkg::result_t out_q;

	// parser steps when the result register is free or being drained
	assign advance  = valid_s1 & (~out_q.valid | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			end_s1  <= buffer_end;
		end
	end

	wsfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.buffer_end(end_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= res;
		end else if (!out_stall) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid      = out_q.valid;
	assign payload_byte   = out_q.payload_byte;
	assign has_payload    = out_q.has_payload;
	assign frame_end      = out_q.frame_end;
	assign fin            = out_q.fin;
	assign opcode         = out_q.opcode;
	assign masked         = out_q.masked;
	assign payload_length = out_q.payload_length;
	assign incomplete     = out_q.incomplete;

	`WSFD_ASSERT_NOW(a_end_xor_inc, out_valid, !(frame_end && incomplete), "frame_end with incomplete")
	`WSFD_ASSERT_NOW(a_empty_word, out_valid && !has_payload, frame_end || incomplete, "empty word without end")
	`WSFD_ASSERT_NOW(a_zero_pad, out_valid && !has_payload, payload_byte == 8'd0, "stray payload bits")
	`WSFD_ASSERT_NEXT(a_stall_holds, in_stall && !out_stall, !in_stall, "input stall outlived output stall")

endmodule
